[hw/rtl/pps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  task_id;
    logic [15:0] burst_length;
    logic [7:0]  task_priority;
  } pps_in_t;

  typedef struct packed {
    logic        accepted;
    logic        busy_res;
    logic [7:0]  running_task;
    logic        finished;
    logic [31:0] completion_time;
    logic [31:0] turnaround_time;
    logic [31:0] waiting_time;
  } pps_out_t;

  // One queue entry, as stored in the RAM.
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } pps_entry_t;

  localparam int ENTRY_W = $bits(pps_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_REQ,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT_REQ,
    ST_SHIFT,
    ST_APPEND,
    ST_RUN,
    ST_DONE
  } pps_state_t;

endpackage

[hw/rtl/pps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/preemptive_priority_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Ready queue in RAM, read one entry at a time by a small sequencer.
// Arrival: result in the cycle after the accepted beat.
// Tick: a priority scan of the queue (skipped when it is empty), a decision,
// and on a dispatch a gap-closing shift and a tail append of any displaced
// task, then one run step; the scan reads one RAM entry per cycle.
// One item at a time; in_ready is low while an item is in progress or its
// result is unaccepted. Synchronous reset empties the queue and clears time.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit
  import pps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pps_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pps_out_t out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  pps_state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [AW-1:0] sel;
  logic [7:0]    best;
  logic          best_vld;
  pps_entry_t    run;
  pps_entry_t    pick;
  logic          run_valid;
  logic [31:0]   now;
  pps_out_t      res;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  pps_entry_t    wdata, rdata;
  logic          preempt;

  pps_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign out_data  = res;
  assign preempt   = !run_valid || (run.prio > best);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.kind == KIND_TICK) ? ST_SCAN_REQ : ST_DONE;
        end
      end
      ST_SCAN_REQ: state_next = (count == '0) ? ST_RUN : ST_SCAN;
      ST_SCAN:     state_next = (idx + 1'b1 >= count) ? ST_DECIDE : ST_SCAN;
      ST_DECIDE:   state_next = preempt ? ST_SHIFT_REQ : ST_RUN;
      ST_SHIFT_REQ: state_next = (idx + 1'b1 >= count) ? ST_APPEND : ST_SHIFT;
      ST_SHIFT:    state_next = ST_SHIFT_REQ;
      ST_APPEND:   state_next = ST_RUN;
      ST_RUN:      state_next = ST_DONE;
      ST_DONE:     state_next = out_ready ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // RAM port control.
  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        raddr = '0;
        waddr = count[AW-1:0];
        wdata = '{id: in_data.task_id, arrival: now, burst: in_data.burst_length,
                  remaining: in_data.burst_length, prio: in_data.task_priority};
        we = in_valid && (in_data.kind == KIND_ARRIVAL) && (count < DEPTH_C)
             && (in_data.burst_length != '0);
      end
      ST_SCAN:      raddr = AW'(idx + 1'b1);
      ST_DECIDE:    raddr = sel;
      ST_SHIFT_REQ: raddr = AW'(idx + 1'b1);
      // Close the gap: entry idx+1 moves down to idx.
      ST_SHIFT:     we = 1'b1;
      // The displaced task, still in run, goes to the queue tail.
      ST_APPEND: begin
        waddr = AW'(count - 1'b1);
        wdata = run;
        we    = run_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      run_valid <= 1'b0;
      run       <= '0;
      now       <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          res <= {we || (in_data.kind == KIND_TICK), {($bits(pps_out_t) - 1){1'b0}}};
          if (we) begin
            count <= count + 1'b1;
          end
        end
        ST_SCAN_REQ: begin
          best_vld <= 1'b0;
          sel      <= '0;
        end
        ST_SCAN: begin
          if (!best_vld || rdata.prio < best) begin
            best <= rdata.prio;
            sel  <= idx[AW-1:0];
          end
          best_vld <= 1'b1;
          idx      <= idx + 1'b1;
        end
        ST_DECIDE: idx <= CW'(sel);
        ST_SHIFT_REQ: begin
          // On the first pass rdata holds the selected entry from the DECIDE read.
          if (idx == CW'(sel)) begin
            pick <= rdata;
          end
        end
        ST_SHIFT: idx <= idx + 1'b1;
        ST_APPEND: begin
          if (!run_valid) begin
            count <= count - 1'b1;
          end
          run       <= pick;
          run_valid <= 1'b1;
        end
        ST_RUN: begin
          now <= now + 1'b1;
          if (run_valid && run.remaining != '0) begin
            run.remaining    <= run.remaining - 1'b1;
            res.busy_res     <= 1'b1;
            res.running_task <= run.id;
            if (run.remaining == 16'd1) begin
              res.finished        <= 1'b1;
              res.completion_time <= now + 1'b1;
              res.turnaround_time <= now + 1'b1 - run.arrival;
              res.waiting_time    <= now + 1'b1 - run.arrival - 32'(run.burst);
              run_valid           <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/sv/pps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_checker
// Watches both channels of the scheduler, keeps its own copy of the ready
// queue and running slot, predicts one result per accepted beat and compares.
// ----------------------------------------------------------------------------
module pps_checker
  import pps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  pps_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  pps_out_t out_data,
  output int       fail_count,
  output int       pending
);

  pps_entry_t ready_q[$];
  pps_entry_t runner;
  logic       run_valid;
  logic [31:0] now;
  pps_out_t   sched_expect[$];

  function automatic pps_out_t schedule_step(pps_in_t item);
    pps_out_t   r;
    int         sel;
    pps_entry_t old;
    r = '0;
    if (item.kind == KIND_ARRIVAL) begin
      if (ready_q.size() < QUEUE_DEPTH && item.burst_length != 16'd0) begin
        ready_q.push_back('{id: item.task_id, arrival: now, burst: item.burst_length,
                            remaining: item.burst_length, prio: item.task_priority});
        r.accepted = 1'b1;
      end
      return r;
    end
    r.accepted = 1'b1;
    if (ready_q.size() > 0) begin
      sel = 0;
      for (int k = 1; k < ready_q.size(); k++)
        if (ready_q[k].prio < ready_q[sel].prio) sel = k;
      if (!run_valid) begin
        runner = ready_q[sel];
        ready_q.delete(sel);
        run_valid = 1'b1;
      end else if (runner.prio > ready_q[sel].prio) begin
        old = runner;
        runner = ready_q[sel];
        ready_q.delete(sel);
        ready_q.push_back(old);
      end
    end
    if (run_valid && runner.remaining != 16'd0) begin
      runner.remaining--;
      r.busy_res = 1'b1;
      r.running_task = runner.id;
      if (runner.remaining == 16'd0) begin
        r.finished = 1'b1;
        r.completion_time = now + 32'd1;
        r.turnaround_time = r.completion_time - runner.arrival;
        r.waiting_time = r.turnaround_time - 32'(runner.burst);
        run_valid = 1'b0;
      end
    end
    now++;
    return r;
  endfunction

  assign pending = sched_expect.size();

  always @(posedge clk) begin
    pps_out_t exp_r;
    if (rst) begin
      ready_q.delete();
      sched_expect.delete();
      runner = '0;
      run_valid = 1'b0;
      now = '0;
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) sched_expect.push_back(schedule_step(in_data));
      if (out_valid && out_ready) begin
        if (sched_expect.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result beat %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = sched_expect.pop_front();
          if (exp_r !== out_data) begin
            if (fail_count < 10)
              $display("ERROR: result mismatch expected %p actual %p", exp_r, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/sv/tb_preemptive_priority_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler_unit
// Drives arrivals and ticks into the scheduler with random gaps and stalls,
// including one long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_unit;
  import pps_pkg::*;

  localparam int DEPTH = 16;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pps_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pps_out_t out_data;
  int       fail_count;
  int       pending;
  bit       hold_off = 1'b0;
  bit       stim_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  preemptive_priority_scheduler_unit #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  pps_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Presents one beat and waits for it to be taken.
  task automatic send_item(logic k, logic [7:0] id, logic [15:0] bl, logic [7:0] pr);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: k, task_id: id, burst_length: bl, task_priority: pr};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_arrival(logic [7:0] id, logic [15:0] bl, logic [7:0] pr);
    send_item(KIND_ARRIVAL, id, bl, pr);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: field extremes, zero burst, equal priority, preemption, full queue.
    send_arrival(8'hFF, 16'hFFFF, 8'hFF);
    send_arrival(8'h00, 16'd0, 8'h00);
    send_tick();
    send_arrival(8'h01, 16'd2, 8'hFF);
    send_tick();
    send_arrival(8'h02, 16'd1, 8'h00);
    send_tick();
    send_tick();
    send_arrival(8'h03, 16'd1, 8'hFF);
    for (int i = 0; i < DEPTH + 1; i++) send_arrival(8'(i + 16), 16'd1, 8'h80);
    repeat (4) send_tick();
    // Long hold-off while the sender keeps offering beats.
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (8) send_tick();
    join
    for (int n = 0; n < 830; n++) begin
      if ($urandom_range(0, 1) == 0)
        send_arrival(8'($urandom), 16'($urandom_range(0, 9) == 0 ?
                     $urandom_range(0, 65535) : $urandom_range(0, 6)), 8'($urandom_range(0, 255)
                     >> ($urandom_range(0, 1) * 5)));
      else
        send_tick();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
